/* hw/rtl/phu_pkg.sv */
package phu_pkg;

	localparam int KIND_W = 4;
	localparam int PC_W = 32;
	localparam int REG_W = 5;

	localparam logic [KIND_W-1:0] KIND_NOP = 4'd0;
	localparam logic [KIND_W-1:0] KIND_RTYPE = 4'd1;
	localparam logic [KIND_W-1:0] KIND_ITYPE = 4'd2;
	localparam logic [KIND_W-1:0] KIND_LOAD = 4'd3;
	localparam logic [KIND_W-1:0] KIND_STORE = 4'd4;
	localparam logic [KIND_W-1:0] KIND_BRANCH = 4'd5;
	localparam logic [KIND_W-1:0] KIND_JUMP = 4'd6;
	localparam logic [KIND_W-1:0] KIND_JR = 4'd8;

	typedef enum logic [1:0] {
		CAUSE_NONE = 2'd0,
		CAUSE_LOAD_USE = 2'd1,
		CAUSE_CONTROL = 2'd2,
		CAUSE_JUMP = 2'd3
	} cause_t;

	typedef enum logic [1:0] {
		ENTRY_NOT_TAKEN = 2'd0,
		ENTRY_TAKEN = 2'd1,
		ENTRY_UNSET = 2'd2
	} entry_t;

	// what the hazard check hands to the slot sequencer for one item
	typedef struct packed {
		logic [1:0] bubbles;
		cause_t cause;
	} slot_req_t;

endpackage

/* hw/rtl/phu_if.sv */
interface phu_instr_if import phu_pkg::*; ();
	logic valid;
	logic ready;
	logic [KIND_W-1:0] kind;
	logic [PC_W-1:0] pc;
	logic [REG_W-1:0] src_reg_a;
	logic [REG_W-1:0] src_reg_b;
	logic [REG_W-1:0] dest_reg;

	modport source (output valid, kind, pc, src_reg_a, src_reg_b, dest_reg, input ready);
	modport sink (input valid, kind, pc, src_reg_a, src_reg_b, dest_reg, output ready);
endinterface

interface phu_slot_if import phu_pkg::*; ();
	logic valid;
	logic ready;
	logic slot_is_bubble;
	cause_t cause;
	logic last;

	modport source (output valid, slot_is_bubble, cause, last, input ready);
	modport sink (input valid, slot_is_bubble, cause, last, output ready);
endinterface

/* hw/rtl/pipeline_hazard_unit_one_bit_predictor.sv */
// Fetch-side hazard unit with a one-bit branch predictor.
// instr carries one fetched instruction per item (kind, pc, source and
// destination registers); slot carries the slots that item causes: zero,
// one or two bubbles, each with its cause, then one slot with last high
// that admits the instruction into the fetch stage.
// cfg_we/cfg_wdata write prediction_on at a clock edge. The user must do
// so only while the unit is idle; the block itself does not enforce this.
// The first slot of an item is shown on the cycle after it is accepted.
// With no hazards one item is taken every cycle while the receiver takes
// every slot; a load-use, branch mispredict or jump ahead adds bubbles.
// The history table is read one item ahead, when the branch itself is
// accepted, so its registered read port keeps that rate.
// Reset: fetch stage holds a nop at pc 0, prediction is off, and the
// history table is swept to unset, one entry a cycle, while instr.ready
// stays low.
// A stalled receiver holds the current slot; a new item is taken only in
// the cycle the admitting slot of the previous one is taken, or when the
// slot register is empty.
module pipeline_hazard_unit_one_bit_predictor import phu_pkg::*; #(
	parameter int TABLE_ENTRIES = 128
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_wdata,
	phu_instr_if.sink instr,
	phu_slot_if.source slot
);

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

	logic pred_on_q;
	logic [KIND_W-1:0] fetch_kind_q;
	logic [PC_W-1:0] fetch_pc_q;
	logic [REG_W-1:0] fetch_dest_q;
	logic [IDX_W-1:0] fetch_idx_q;

	logic accept;
	logic can_take;
	logic bht_busy;
	entry_t bht_code;
	logic [IDX_W-1:0] next_idx;

	logic load_use;
	logic taken;
	logic miss;
	logic control;
	logic jump_ahead;
	logic bht_wr;
	slot_req_t req;

	assign accept = instr.valid && instr.ready;
	assign instr.ready = can_take && !bht_busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pred_on_q <= 1'b0;
		end else if (cfg_we) begin
			pred_on_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fetch_kind_q <= KIND_NOP;
			fetch_pc_q <= '0;
			fetch_dest_q <= '0;
			fetch_idx_q <= '0;
		end else if (accept) begin
			fetch_kind_q <= instr.kind;
			fetch_pc_q <= instr.pc;
			fetch_dest_q <= instr.dest_reg;
			fetch_idx_q <= next_idx;
		end
	end

	always_comb begin
		load_use = 1'b0;
		if (fetch_kind_q == KIND_LOAD) begin
			if (instr.kind == KIND_RTYPE || instr.kind == KIND_BRANCH) begin
				load_use = fetch_dest_q == instr.src_reg_a || fetch_dest_q == instr.src_reg_b;
			end else if (instr.kind == KIND_ITYPE || instr.kind == KIND_STORE) begin
				load_use = fetch_dest_q == instr.src_reg_a;
			end
		end
	end

	// taken when the successor is not the fall-through address
	assign taken = instr.pc != (fetch_pc_q + PC_W'(4));
	assign miss = (pred_on_q && bht_code == ENTRY_TAKEN) ? !taken : taken;
	assign control = fetch_kind_q == KIND_BRANCH && miss;
	assign jump_ahead = fetch_kind_q == KIND_JUMP || fetch_kind_q == KIND_JR;
	assign bht_wr = accept && fetch_kind_q == KIND_BRANCH && pred_on_q;

	always_comb begin
		priority if (load_use) begin
			req.bubbles = 2'd1;
			req.cause = CAUSE_LOAD_USE;
		end else if (control) begin
			req.bubbles = 2'd2;
			req.cause = CAUSE_CONTROL;
		end else if (jump_ahead) begin
			req.bubbles = 2'd2;
			req.cause = CAUSE_JUMP;
		end else begin
			req.bubbles = 2'd0;
			req.cause = CAUSE_NONE;
		end
	end

	phu_index #(
		.ENTRIES(TABLE_ENTRIES),
		.IDX_W(IDX_W)
	) u_index (
		.pc(instr.pc),
		.idx(next_idx)
	);

	phu_bht #(
		.ENTRIES(TABLE_ENTRIES),
		.IDX_W(IDX_W)
	) u_bht (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(bht_wr),
		.wr_idx(fetch_idx_q),
		.wr_taken(taken),
		.rd_en(accept),
		.rd_idx(next_idx),
		.rd_code(bht_code),
		.busy(bht_busy)
	);

	phu_slot u_slot (
		.clk(clk),
		.arst_n(arst_n),
		.load(accept),
		.req(req),
		.can_take(can_take),
		.slot(slot)
	);

	a_no_accept_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> !bht_busy)
		else $error("item accepted during history table clear");

	a_clean_item_admits_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.bubbles == 2'd0 |=> slot.valid && slot.last && !slot.slot_is_bubble)
		else $error("hazard-free item not admitted on the next slot");

	a_bubble_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		slot.valid && slot.slot_is_bubble |-> slot.cause != CAUSE_NONE && !slot.last)
		else $error("bubble slot without a cause");

	a_update_only_on_branch: assert property (@(posedge clk) disable iff (!arst_n)
		bht_wr |-> !load_use && pred_on_q)
		else $error("history table written outside a predicted branch");

endmodule

/* hw/rtl/phu_index.sv */
module phu_index import phu_pkg::*; #(
	parameter int ENTRIES = 128,
	parameter int IDX_W = 7
) (
	input logic [PC_W-1:0] pc,
	output logic [IDX_W-1:0] idx
);

	localparam int NIBS = (PC_W - 4) / 4;
	localparam int SUM_W = IDX_W + 3;

	// residue of each nibble of pc >> 4 at its weight, worked out at elaboration
	logic [IDX_W-1:0] res_tab [NIBS][16];
	logic [SUM_W-1:0] sum;
	logic [SUM_W-1:0] red;

	for (genvar i = 0; i < NIBS; i++) begin : g_nib
		for (genvar d = 0; d < 16; d++) begin : g_dig
			assign res_tab[i][d] = IDX_W'((d * (1 << (4 * i))) % ENTRIES);
		end
	end

	always_comb begin
		sum = '0;
		for (int i = 0; i < NIBS; i++) begin
			sum = sum + SUM_W'(res_tab[i][pc[4 * i + 4 +: 4]]);
		end
	end

	// sum stays below seven times the table size: take off the largest fitting multiple
	always_comb begin
		red = sum;
		for (int k = 1; k < NIBS; k++) begin
			if (sum >= SUM_W'(k * ENTRIES)) begin
				red = sum - SUM_W'(k * ENTRIES);
			end
		end
	end

	assign idx = red[IDX_W-1:0];

endmodule

/* hw/rtl/phu_bht.sv */
module phu_bht import phu_pkg::*; #(
	parameter int ENTRIES = 128,
	parameter int IDX_W = 7
) (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input logic [IDX_W-1:0] wr_idx,
	input logic wr_taken,
	input logic rd_en,
	input logic [IDX_W-1:0] rd_idx,
	output entry_t rd_code,
	output logic busy
);

	entry_t mem [ENTRIES];
	logic [IDX_W-1:0] clr_cnt_q;
	logic busy_q;
	entry_t rd_code_q;
	entry_t wr_code;

	assign wr_code = wr_taken ? ENTRY_TAKEN : ENTRY_NOT_TAKEN;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b1;
			clr_cnt_q <= '0;
		end else if (busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == IDX_W'(ENTRIES - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_cnt_q] <= ENTRY_UNSET;
		end else if (wr_en) begin
			mem[wr_idx] <= wr_code;
		end
	end

	// a lookup of the entry being updated this cycle sees the new outcome
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_code_q <= ENTRY_UNSET;
		end else if (rd_en) begin
			if (wr_en && wr_idx == rd_idx) begin
				rd_code_q <= wr_code;
			end else begin
				rd_code_q <= mem[rd_idx];
			end
		end
	end

	assign rd_code = rd_code_q;
	assign busy = busy_q;

endmodule

/* hw/rtl/phu_slot.sv */
module phu_slot import phu_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic load,
	input slot_req_t req,
	output logic can_take,
	phu_slot_if.source slot
);

	logic valid_s1;
	logic [1:0] left_s1;
	cause_t cause_s1;
	logic done;

	assign done = left_s1 == 2'd0;
	assign can_take = !valid_s1 || (slot.ready && done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (slot.valid && slot.ready && done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			left_s1 <= req.bubbles;
			cause_s1 <= req.cause;
		end else if (slot.valid && slot.ready && !done) begin
			left_s1 <= left_s1 - 2'd1;
		end
	end

	assign slot.valid = valid_s1;
	assign slot.slot_is_bubble = !done;
	assign slot.cause = done ? CAUSE_NONE : cause_s1;
	assign slot.last = done;

endmodule

/* sim/phu_slot_checker.sv */
`timescale 1ns / 100ps

module phu_slot_checker import phu_pkg::*; #(
	parameter int TABLE_ENTRIES = 128
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic cfg_wdata,
	phu_instr_if instr,
	phu_slot_if slot,
	output int fail_count,
	output int slots_owed
);

	typedef struct packed {
		logic bubble;
		cause_t cause;
		logic last;
	} slot_exp_t;

	slot_exp_t owed_slots[$];

	logic prediction_on;
	logic [KIND_W-1:0] held_kind;
	logic [PC_W-1:0] held_pc;
	logic [REG_W-1:0] held_dest;
	entry_t history [TABLE_ENTRIES];

	initial begin
		fail_count = 0;
		slots_owed = 0;
	end

	task automatic check_field(input string field, input logic [1:0] want, input logic [1:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d actual %0d", $time, field, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : track
		logic stall;
		logic taken;
		logic miss;
		int unsigned idx;
		int bubbles;
		cause_t why;
		slot_exp_t want;
		if (!arst_n) begin
			prediction_on = 1'b0;
			held_kind = KIND_NOP;
			held_pc = '0;
			held_dest = '0;
			foreach (history[i])
				history[i] = ENTRY_UNSET;
			owed_slots.delete();
		end else begin
			if (cfg_we)
				prediction_on = cfg_wdata;

			if (slot.valid && slot.ready) begin
				if (owed_slots.size() == 0) begin
					$display("%0t: slot with none owed, expected none actual bubble %0d cause %0d last %0d",
						$time, slot.slot_is_bubble, slot.cause, slot.last);
					fail_count++;
				end else begin
					want = owed_slots.pop_front();
					check_field("slot_is_bubble", want.bubble, slot.slot_is_bubble);
					check_field("cause", want.cause, slot.cause);
					check_field("last", want.last, slot.last);
				end
			end

			// slots of this item queue behind those of the one just finished
			if (instr.valid && instr.ready) begin
				stall = 1'b0;
				miss = 1'b0;
				bubbles = 0;
				why = CAUSE_NONE;
				if (held_kind == KIND_LOAD) begin
					case (instr.kind)
						KIND_RTYPE, KIND_BRANCH: begin
							stall = held_dest == instr.src_reg_a || held_dest == instr.src_reg_b;
						end
						KIND_ITYPE, KIND_STORE: begin
							stall = held_dest == instr.src_reg_a;
						end
						default: begin
							stall = 1'b0;
						end
					endcase
				end

				if (stall) begin
					why = CAUSE_LOAD_USE;
					bubbles = 1;
				end else if (held_kind == KIND_BRANCH) begin
					taken = instr.pc != held_pc + 32'd4;
					if (prediction_on) begin
						idx = (held_pc >> 4) % TABLE_ENTRIES;
						// unset entries predict not taken
						miss = (history[idx] == ENTRY_TAKEN) ? !taken : taken;
						history[idx] = taken ? ENTRY_TAKEN : ENTRY_NOT_TAKEN;
					end else begin
						miss = taken;
					end
					if (miss) begin
						why = CAUSE_CONTROL;
						bubbles = 2;
					end
				end else if (held_kind == KIND_JUMP || held_kind == KIND_JR) begin
					why = CAUSE_JUMP;
					bubbles = 2;
				end

				repeat (bubbles)
					owed_slots.push_back('{1'b1, why, 1'b0});
				owed_slots.push_back('{1'b0, CAUSE_NONE, 1'b1});

				held_kind = instr.kind;
				held_pc = instr.pc;
				held_dest = instr.dest_reg;
			end
		end
		slots_owed = owed_slots.size();
	end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
	import phu_pkg::*;

	localparam int TABLE_ENTRIES = 128;
	localparam int CYCLE_LIMIT = 200000;
	localparam logic [KIND_W-1:0] KIND_SPECIAL = 4'd7;
	localparam logic [KIND_W-1:0] KIND_LAST = 4'd15;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	int fail_count;
	int slots_owed;
	bit idle_on;

	logic [PC_W-1:0] prev_pc;
	logic [KIND_W-1:0] prev_kind;
	logic [REG_W-1:0] prev_dest;
	int loop_idx;
	logic [PC_W-1:0] loop_pc [8];
	int unsigned taken_odds [8];

	phu_instr_if instr_ch ();
	phu_slot_if slot_ch ();

	pipeline_hazard_unit_one_bit_predictor #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.instr(instr_ch),
		.slot(slot_ch)
	);

	phu_slot_checker #(
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) slot_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.instr(instr_ch),
		.slot(slot_ch),
		.fail_count(fail_count),
		.slots_owed(slots_owed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TEST FAILED");
		$finish;
	end

	// receiver stalls in bursts
	initial begin : slot_sink
		int stall_left;
		stall_left = 0;
		slot_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				slot_ch.ready <= 1'b0;
				stall_left--;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				slot_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 11);
			end else begin
				slot_ch.ready <= 1'b1;
			end
		end
	end

	task automatic send_instr(input logic [KIND_W-1:0] kind, input logic [PC_W-1:0] pc,
			input logic [REG_W-1:0] ra, input logic [REG_W-1:0] rb, input logic [REG_W-1:0] rd);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			instr_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		instr_ch.valid <= 1'b1;
		instr_ch.kind <= kind;
		instr_ch.pc <= pc;
		instr_ch.src_reg_a <= ra;
		instr_ch.src_reg_b <= rb;
		instr_ch.dest_reg <= rd;
		do
			@(posedge clk);
		while (!instr_ch.ready);
		@(negedge clk);
		prev_kind = kind;
		prev_pc = pc;
		prev_dest = rd;
	endtask

	task automatic drain();
		instr_ch.valid <= 1'b0;
		while (slots_owed != 0)
			@(negedge clk);
	endtask

	task automatic set_prediction(input logic on);
		cfg_we <= 1'b1;
		cfg_wdata <= on;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_random();
		logic [KIND_W-1:0] kind;
		logic [PC_W-1:0] pc;
		logic [REG_W-1:0] ra;
		logic [REG_W-1:0] rb;
		logic [REG_W-1:0] rd;
		int pick;
		logic taken;
		pick = $urandom_range(0, 99);
		if (pick < 14)
			kind = KIND_LOAD;
		else if (pick < 28)
			kind = KIND_RTYPE;
		else if (pick < 38)
			kind = KIND_ITYPE;
		else if (pick < 46)
			kind = KIND_STORE;
		else if (pick < 64)
			kind = KIND_BRANCH;
		else if (pick < 70)
			kind = KIND_JUMP;
		else if (pick < 76)
			kind = KIND_JR;
		else if (pick < 82)
			kind = KIND_NOP;
		else
			kind = KIND_W'($urandom_range(KIND_SPECIAL, KIND_LAST));

		// successor of a branch follows that branch's bias
		if (prev_kind == KIND_BRANCH) begin
			if (loop_idx >= 0)
				taken = $urandom_range(0, 7) < taken_odds[loop_idx];
			else
				taken = 1'($urandom_range(0, 1));
			pc = taken ? $urandom() : prev_pc + 32'd4;
		end else if ($urandom_range(0, 15) == 0) begin
			pc = $urandom();
		end else begin
			pc = prev_pc + 32'd4;
		end

		loop_idx = -1;
		if (kind == KIND_BRANCH && prev_kind != KIND_BRANCH && $urandom_range(0, 3) != 0) begin
			loop_idx = $urandom_range(0, 7);
			pc = loop_pc[loop_idx];
		end

		ra = REG_W'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 31));
		rb = REG_W'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 31));
		rd = REG_W'($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 31));
		if (prev_kind == KIND_LOAD && $urandom_range(0, 1)) begin
			if ($urandom_range(0, 1))
				ra = prev_dest;
			else
				rb = prev_dest;
		end
		send_instr(kind, pc, ra, rb, rd);
	endtask

	initial begin : stimulus
		logic phase_cfg [4];
		int phase_items [4];
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		instr_ch.valid = 1'b0;
		instr_ch.kind = KIND_NOP;
		instr_ch.pc = '0;
		instr_ch.src_reg_a = '0;
		instr_ch.src_reg_b = '0;
		instr_ch.dest_reg = '0;
		idle_on = 1'b1;
		prev_pc = '0;
		prev_kind = KIND_NOP;
		prev_dest = '0;
		loop_idx = -1;
		phase_cfg = '{1'b0, 1'b1, 1'b0, 1'b1};
		phase_items = '{120, 120, 100, 140};
		for (int i = 0; i < 7; i++) begin
			loop_pc[i] = 32'h0000_4000 + i * 32'h30;
			taken_odds[i] = (i % 2) ? 1 : 7;
		end
		// same table index as the first loop branch
		loop_pc[7] = loop_pc[0] + 32'h800;
		taken_odds[7] = 4;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// prediction off: load-use, branch and jump cases
		send_instr(KIND_LOAD, 32'h0000_0000, 5'd0, 5'd0, 5'd5);
		send_instr(KIND_RTYPE, 32'h0000_0004, 5'd7, 5'd5, 5'd1);
		send_instr(KIND_LOAD, 32'h0000_0008, 5'd2, 5'd3, 5'd0);
		send_instr(KIND_STORE, 32'h0000_000C, 5'd0, 5'd9, 5'd0);
		send_instr(KIND_LOAD, 32'h0000_0010, 5'd4, 5'd4, 5'd31);
		send_instr(KIND_ITYPE, 32'h0000_0014, 5'd1, 5'd31, 5'd2);
		send_instr(KIND_LOAD, 32'h0000_0018, 5'd4, 5'd4, 5'd31);
		send_instr(KIND_BRANCH, 32'h0000_001C, 5'd31, 5'd0, 5'd0);
		send_instr(KIND_RTYPE, 32'h0000_0020, 5'd1, 5'd2, 5'd3);
		send_instr(KIND_BRANCH, 32'hFFFF_FFFC, 5'd1, 5'd2, 5'd0);
		send_instr(KIND_NOP, 32'h0000_0000, 5'd0, 5'd0, 5'd0);
		send_instr(KIND_BRANCH, 32'h0000_0100, 5'd1, 5'd2, 5'd0);
		send_instr(KIND_ITYPE, 32'h0000_0300, 5'd3, 5'd0, 5'd4);
		send_instr(KIND_JUMP, 32'h0000_0304, 5'd0, 5'd0, 5'd0);
		send_instr(KIND_RTYPE, 32'h0000_1000, 5'd5, 5'd6, 5'd7);
		send_instr(KIND_JR, 32'h0000_1004, 5'd31, 5'd0, 5'd0);
		send_instr(KIND_LAST, 32'hFFFF_FFFF, 5'd31, 5'd31, 5'd31);
		send_instr(KIND_SPECIAL, 32'h0000_0000, 5'd0, 5'd0, 5'd0);
		drain();
		set_prediction(1'b1);

		// one-bit history: miss on unset, hit, miss via alias, hit
		send_instr(KIND_BRANCH, 32'h0000_0040, 5'd1, 5'd2, 5'd0);
		send_instr(KIND_RTYPE, 32'h0000_0080, 5'd3, 5'd4, 5'd5);
		send_instr(KIND_BRANCH, 32'h0000_0040, 5'd1, 5'd2, 5'd0);
		send_instr(KIND_RTYPE, 32'h0000_0090, 5'd3, 5'd4, 5'd5);
		send_instr(KIND_BRANCH, 32'h0000_0840, 5'd1, 5'd2, 5'd0);
		send_instr(KIND_RTYPE, 32'h0000_0844, 5'd3, 5'd4, 5'd5);
		send_instr(KIND_BRANCH, 32'h0000_0040, 5'd1, 5'd2, 5'd0);
		send_instr(KIND_RTYPE, 32'h0000_0044, 5'd3, 5'd4, 5'd5);

		for (int p = 0; p < 4; p++) begin
			drain();
			set_prediction(phase_cfg[p]);
			idle_on = p < 3;
			repeat (phase_items[p])
				send_random();
		end
		drain();
		repeat (4) @(negedge clk);

		if (fail_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
